### sv/slxr_pkg.sv
// Package with shared types and constants for the sync/length/XOR frame receiver.
`timescale 1ns / 1ps

package slxr_pkg;

  localparam logic [7:0] SYNC_FIRST = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [7:0] RESET_ACCEPTED_TYPE = 8'h01;
  localparam logic [15:0] RESET_MAX_LEN = 16'd256;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_MAX_LEN = 1'b0;
  localparam logic REG_ACCEPTED_TYPE = 1'b1;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD = 2'd1;
  localparam logic [1:0] KIND_BAD = 2'd2;

  typedef struct packed {
    logic [15:0] max_payload_len;
    logic [7:0]  accepted_type;
  } cfg_t;

endpackage

### sv/slxr_cfg.sv
// APB register file holding the maximum payload length and the accepted frame type.
`timescale 1ns / 1ps

module slxr_cfg
  import slxr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t regs;
  logic write_en;
  logic reg_sel;

  assign pready   = 1'b1;
  assign write_en = psel & penable & pwrite & pready;
  assign reg_sel  = paddr[2];
  assign cfg      = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.max_payload_len <= RESET_MAX_LEN;
      regs.accepted_type   <= RESET_ACCEPTED_TYPE;
    end else if (write_en) begin
      unique case (reg_sel)
        REG_MAX_LEN:       regs.max_payload_len <= pwdata[15:0];
        REG_ACCEPTED_TYPE: regs.accepted_type   <= pwdata[7:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MAX_LEN:       prdata = {16'd0, regs.max_payload_len};
      REG_ACCEPTED_TYPE: prdata = {24'd0, regs.accepted_type};
      default:           prdata = '0;
    endcase
  end

endmodule

### sv/slxr_parser.sv
// Frame parser with an input register, the framing state machine and a result register.
`timescale 1ns / 1ps

module slxr_parser
  import slxr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  result_kind,
  output logic [15:0] frame_length
);

  localparam logic [2:0] PH_SYNC1   = 3'd0;
  localparam logic [2:0] PH_SYNC2   = 3'd1;
  localparam logic [2:0] PH_TYPE    = 3'd2;
  localparam logic [2:0] PH_LEN_LO  = 3'd3;
  localparam logic [2:0] PH_LEN_HI  = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_CHECK   = 3'd6;

  logic        in_full;
  logic [7:0]  in_byte;
  logic        advance;

  logic [2:0]  phase, phase_next;
  logic [7:0]  frame_kind, frame_kind_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] bytes_received, bytes_received_next;
  logic [7:0]  running_xor, running_xor_next;
  logic        emit;
  logic [1:0]  kind;
  logic [15:0] count_inc;
  logic [15:0] full_length;
  logic        type_match;

  assign advance  = in_full & (~out_valid | out_ready);
  assign in_ready = ~in_full | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  assign count_inc   = bytes_received + 16'd1;
  assign full_length = {in_byte, payload_length[7:0]};
  assign type_match  = (frame_kind == cfg.accepted_type);

  always_comb begin
    phase_next          = phase;
    frame_kind_next     = frame_kind;
    payload_length_next = payload_length;
    bytes_received_next = bytes_received;
    running_xor_next    = running_xor;
    emit                = 1'b0;
    kind                = KIND_PAYLOAD;
    unique case (phase)
      PH_SYNC2: begin
        if (in_byte == SYNC_SECOND) begin
          running_xor_next = running_xor ^ in_byte;
          phase_next       = PH_TYPE;
        end else begin
          phase_next = PH_SYNC1;
        end
      end
      PH_TYPE: begin
        frame_kind_next  = in_byte;
        running_xor_next = running_xor ^ in_byte;
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        payload_length_next = {8'd0, in_byte};
        running_xor_next    = running_xor ^ in_byte;
        phase_next          = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        payload_length_next = full_length;
        running_xor_next    = running_xor ^ in_byte;
        if (full_length > cfg.max_payload_len) begin
          phase_next = PH_SYNC1;
        end else begin
          bytes_received_next = '0;
          phase_next = (full_length == 16'd0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        running_xor_next    = running_xor ^ in_byte;
        bytes_received_next = count_inc;
        emit                = type_match;
        kind                = KIND_PAYLOAD;
        if (count_inc >= payload_length) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        emit       = type_match;
        kind       = (in_byte == running_xor) ? KIND_GOOD : KIND_BAD;
        phase_next = PH_SYNC1;
      end
      default: begin
        if (in_byte == SYNC_FIRST) begin
          running_xor_next = in_byte;
          phase_next       = PH_SYNC2;
        end else begin
          phase_next = PH_SYNC1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SYNC1;
      frame_kind     <= '0;
      payload_length <= '0;
      bytes_received <= '0;
      running_xor    <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      frame_kind     <= frame_kind_next;
      payload_length <= payload_length_next;
      bytes_received <= bytes_received_next;
      running_xor    <= running_xor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_byte     <= in_byte;
      result_kind  <= kind;
      frame_length <= payload_length;
    end
  end

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_kind != 2'd3)
    else $error("Result transaction carries an illegal kind.");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_full && !advance) |=> (in_full && $stable(in_byte)))
    else $error("Held input byte was lost or changed.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> bytes_received < payload_length)
    else $error("Payload byte count reached the frame length.");

  a_check_entry: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CHECK && $past(phase) != PH_CHECK) |->
      ($past(phase) == PH_LEN_HI || $past(phase) == PH_PAYLOAD))
    else $error("Checksum phase entered from an unexpected phase.");

endmodule

### sv/sync_length_xor_frame_receiver.sv
// Top level of the sync/length/XOR frame receiver.
//
// The receiver takes one serial byte per input transaction (in_valid, in_ready,
// rx_byte) and hunts for frames made of 0x55, 0xAA, a type byte, a little-endian
// 16-bit length, the payload and an XOR checksum over all earlier frame bytes.
// For frames whose type equals accepted_type, every payload byte leaves as an
// output transaction with result_kind 0, and the checksum byte leaves with
// result_kind 1 when the checksum is good and 2 when it is bad. Frames longer
// than max_payload_len are dropped without any output.
// An accepted byte passes through the input register and the state update, and its
// result is registered in the result register. One byte is taken in every cycle while
// the output is not stalled; the state update of the framing machine sets that rate.
// When the output is stalled, the result register and the input register hold
// one transaction each and in_ready falls until out_ready returns.
// Synchronous reset sets both registers to their defaults (256 and 1), empties
// the pipeline and returns the parser to hunting for the first sync byte.
// Registers sit at APB byte addresses 0 and 4; pready is always high.
`timescale 1ns / 1ps

module sync_length_xor_frame_receiver
  import slxr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic [1:0]        result_kind,
  output logic [15:0]       frame_length
);

  cfg_t cfg;

  slxr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  slxr_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .result_kind  (result_kind),
    .frame_length (frame_length)
  );

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the sync/length/XOR frame receiver.
`timescale 1ns / 1ps

module testbench
  import slxr_pkg::*;
();

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, TAKE_TYPE, LEN_LOW, LEN_HIGH, TAKE_PAYLOAD, TAKE_CHECKSUM
  } parse_phase_e;

  typedef struct packed {
    logic [7:0]  data;
    logic [1:0]  kind;
    logic [15:0] length;
  } frame_result_t;

  typedef struct packed {
    logic [7:0]    rx;
    bit            typed;
    frame_result_t want;
  } link_item_t;

  localparam frame_result_t NO_RESULT = '0;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DIRECTED_ROWS = 28;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        rx_byte;
  logic              out_valid;
  logic              out_ready;
  logic [7:0]        out_byte;
  logic [1:0]        result_kind;
  logic [15:0]       frame_length;

  sync_length_xor_frame_receiver dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .result_kind(result_kind), .frame_length(frame_length)
  );

  link_item_t    link_bytes[$];
  frame_result_t pending_results[$];
  link_item_t    directed_rows [DIRECTED_ROWS];
  int            error_count = 0;
  int            cycle_count = 0;
  int            bytes_queued = 0;

  logic [15:0]  cfg_max_len;
  logic [7:0]   cfg_type;
  parse_phase_e parse_phase;
  logic [7:0]   cur_type;
  logic [15:0]  cur_len;
  logic [15:0]  payload_taken;
  logic [7:0]   xor_acc;

  always #1 clk = ~clk;

  function automatic void parse_byte(input logic [7:0] b, output bit emits,
                                     output frame_result_t res);
    emits = 1'b0;
    res = NO_RESULT;
    case (parse_phase)
      HUNT_SECOND: begin
        if (b == SYNC_SECOND) begin
          xor_acc = xor_acc ^ b;
          parse_phase = TAKE_TYPE;
        end else begin
          parse_phase = HUNT_FIRST;
        end
      end
      TAKE_TYPE: begin
        cur_type = b;
        xor_acc = xor_acc ^ b;
        parse_phase = LEN_LOW;
      end
      LEN_LOW: begin
        cur_len = {8'h00, b};
        xor_acc = xor_acc ^ b;
        parse_phase = LEN_HIGH;
      end
      LEN_HIGH: begin
        cur_len[15:8] = b;
        xor_acc = xor_acc ^ b;
        if (cur_len > cfg_max_len) begin
          parse_phase = HUNT_FIRST;
        end else begin
          payload_taken = '0;
          parse_phase = (cur_len == 16'd0) ? TAKE_CHECKSUM : TAKE_PAYLOAD;
        end
      end
      TAKE_PAYLOAD: begin
        xor_acc = xor_acc ^ b;
        payload_taken = payload_taken + 16'd1;
        if (cur_type == cfg_type) begin
          emits = 1'b1;
          res = '{b, KIND_PAYLOAD, cur_len};
        end
        if (payload_taken >= cur_len) parse_phase = TAKE_CHECKSUM;
      end
      TAKE_CHECKSUM: begin
        if (cur_type == cfg_type) begin
          emits = 1'b1;
          res = '{b, (b == xor_acc) ? KIND_GOOD : KIND_BAD, cur_len};
        end
        parse_phase = HUNT_FIRST;
      end
      default: begin
        if (b == SYNC_FIRST) begin
          xor_acc = b;
          parse_phase = HUNT_SECOND;
        end else begin
          parse_phase = HUNT_FIRST;
        end
      end
    endcase
  endfunction

  function automatic void compare_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
      error_count++;
    end
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    link_bytes.push_back('{b, 1'b0, NO_RESULT});
    bytes_queued++;
  endfunction

  task automatic write_reg(input logic idx, input logic [15:0] value);
    logic [31:0] data;
    data = $urandom();
    if (idx == REG_MAX_LEN) data[15:0] = value;
    else data[7:0] = value[7:0];
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_MAX_LEN) cfg_max_len = value;
    else cfg_type = value[7:0];
  endtask

  task automatic add_frame(input bit big);
    logic [7:0]  kind;
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [15:0] len;
    logic [15:0] cap;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom()));
    end else if (pick < 14) begin
      b = 8'($urandom_range(0, 254));
      if (b >= SYNC_SECOND) b = b + 8'd1;
      push_byte(SYNC_FIRST);
      push_byte(b);
    end else begin
      kind = ($urandom_range(0, 3) != 0) ? cfg_type : 8'($urandom());
      cap = (cfg_max_len < 16'd48) ? cfg_max_len : 16'd48;
      pick = $urandom_range(0, 99);
      if (big) len = 16'd300;
      else if (pick < 60) len = 16'($urandom_range(0, (cap < 16'd12) ? cap : 12));
      else if (pick < 75) len = cap;
      else if (pick < 88 && cfg_max_len != 16'hFFFF) begin
        if ($urandom_range(0, 1) == 0) len = cfg_max_len + 16'd1;
        else len = 16'($urandom_range(cfg_max_len + 1, 65535));
      end else len = 16'($urandom_range(0, cap));
      sum = SYNC_FIRST ^ SYNC_SECOND ^ kind ^ len[7:0] ^ len[15:8];
      push_byte(SYNC_FIRST);
      push_byte(SYNC_SECOND);
      push_byte(kind);
      push_byte(len[7:0]);
      push_byte(len[15:8]);
      if (len <= cfg_max_len) begin
        repeat (len) begin
          b = 8'($urandom());
          sum = sum ^ b;
          push_byte(b);
        end
        if ($urandom_range(0, 4) == 0) sum = sum ^ 8'($urandom_range(1, 255));
        push_byte(sum);
      end
    end
  endtask

  task automatic queue_random(input int count, input bit big, input bit leave_open);
    int start;
    start = bytes_queued;
    if (big) add_frame(1'b1);
    while (bytes_queued - start < count) add_frame(1'b0);
    if (leave_open) begin
      push_byte(SYNC_FIRST);
      push_byte(SYNC_SECOND);
      push_byte(cfg_type);
      push_byte(8'd3);
      push_byte(8'd0);
      push_byte(8'($urandom()));
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (link_bytes.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps; predicts on acceptance.
  always @(posedge clk) begin : sender
    int            burst_left;
    int            gap_left;
    link_item_t    cur_item;
    frame_result_t predicted;
    bit            emits;
    bit            next_valid;
    if (rst) begin
      in_valid <= 1'b0;
      rx_byte <= '0;
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(rx_byte, emits, predicted);
        if (cur_item.typed) pending_results.push_back(cur_item.want);
        else if (emits) pending_results.push_back(predicted);
      end
      if (!in_valid || in_ready) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (link_bytes.size() != 0) begin
          cur_item = link_bytes.pop_front();
          next_valid = 1'b1;
          rx_byte <= cur_item.rx;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 4))
              0, 1: gap_left = 0;
              2, 3: gap_left = $urandom_range(1, 4);
              default: gap_left = $urandom_range(5, 20);
            endcase
          end
        end
        in_valid <= next_valid;
      end
    end
  end

  // Receiver: random stall windows, plus one long hold-off while input is still offered.
  always @(posedge clk) begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    bit hold_done;
    if (rst) begin
      out_ready <= 1'b0;
      mode = 1;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && link_bytes.size() > 100) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = (mode == 0) ? $urandom_range(1, 6) : $urandom_range(1, 40);
      end
      mode_left--;
      out_ready <= (mode == 1) || (mode == 2 && $urandom_range(0, 1) == 1);
    end
  end

  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, got byte %0h kind %0d length %0h",
                 $time, out_byte, result_kind, frame_length);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("out_byte", 16'(want.data), 16'(out_byte));
        compare_field("result_kind", 16'(want.kind), 16'(result_kind));
        compare_field("frame_length", want.length, frame_length);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_max_len = RESET_MAX_LEN;
    cfg_type = RESET_ACCEPTED_TYPE;
    parse_phase = HUNT_FIRST;
    cur_type = '0;
    cur_len = '0;
    payload_taken = '0;
    xor_acc = '0;
    directed_rows = '{
      '{8'h55, 1'b0, NO_RESULT}, '{8'hAA, 1'b0, NO_RESULT}, '{8'h01, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
      '{8'hFE, 1'b1, '{8'hFE, KIND_GOOD, 16'd0}},
      '{8'h55, 1'b0, NO_RESULT}, '{8'h55, 1'b0, NO_RESULT}, '{8'hAA, 1'b0, NO_RESULT},
      '{8'h55, 1'b0, NO_RESULT}, '{8'hAA, 1'b0, NO_RESULT}, '{8'h01, 1'b0, NO_RESULT},
      '{8'h02, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, '{8'h00, KIND_PAYLOAD, 16'd2}},
      '{8'hFF, 1'b1, '{8'hFF, KIND_PAYLOAD, 16'd2}},
      '{8'h00, 1'b1, '{8'h00, KIND_BAD, 16'd2}},
      '{8'h55, 1'b0, NO_RESULT}, '{8'hAA, 1'b0, NO_RESULT}, '{8'h01, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, NO_RESULT}, '{8'h01, 1'b0, NO_RESULT},
      '{8'h55, 1'b0, NO_RESULT}, '{8'hAA, 1'b0, NO_RESULT}, '{8'h02, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT}, '{8'hFD, 1'b0, NO_RESULT}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < DIRECTED_ROWS; i++) link_bytes.push_back(directed_rows[i]);
    drain();
    queue_random(180, 1'b0, 1'b0);
    drain();
    write_reg(REG_MAX_LEN, 16'd0);
    write_reg(REG_ACCEPTED_TYPE, 16'd0);
    queue_random(150, 1'b0, 1'b1);
    drain();
    write_reg(REG_MAX_LEN, 16'hFFFF);
    write_reg(REG_ACCEPTED_TYPE, 16'd255);
    queue_random(200, 1'b1, 1'b1);
    drain();
    write_reg(REG_MAX_LEN, 16'd5);
    write_reg(REG_ACCEPTED_TYPE, 16'($urandom_range(0, 255)));
    queue_random(180, 1'b0, 1'b1);
    drain();
    write_reg(REG_MAX_LEN, 16'($urandom_range(6, 40)));
    write_reg(REG_ACCEPTED_TYPE, 16'd1);
    queue_random(180, 1'b0, 1'b0);
    drain();
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### sync_length_xor_frame_receiver.f
sv/slxr_pkg.sv
sv/slxr_cfg.sv
sv/slxr_parser.sv
sv/sync_length_xor_frame_receiver.sv
tb/sv/testbench.sv
